// File: hdl/spq_pkg.sv
// ============================================================================
// spq_pkg
// shared types and constants of the sorted priority queue
// ============================================================================
package spq_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int ID_W   = 32;
    localparam int PRIO_W = 16;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic ins;
        logic rem;
        logic scan;
    } spq_ctrl_t;

    typedef struct packed {
        logic                     found;
        logic signed [PRIO_W-1:0] prio;
    } spq_scan_t;

endpackage

// File: hdl/spq_cell.sv
// ============================================================================
// spq_cell
// one slot of the queue: holds a job, shifts on insert and remove, and
// passes the first-match search result down the chain
// ============================================================================
module spq_cell
    import spq_pkg::*;
(
    input  logic                     clk,
    input  spq_ctrl_t                ctrl,
    input  logic                     occ,
    input  logic                     prev_gt,
    input  logic [ID_W-1:0]          new_id,
    input  logic signed [PRIO_W-1:0] new_prio,
    input  logic [ID_W-1:0]          key,
    input  logic [ID_W-1:0]          prev_id,
    input  logic signed [PRIO_W-1:0] prev_prio,
    input  logic [ID_W-1:0]          next_id,
    input  logic signed [PRIO_W-1:0] next_prio,
    input  spq_scan_t                scan_in,
    output logic                     gt,
    output logic [ID_W-1:0]          id,
    output logic signed [PRIO_W-1:0] prio,
    output spq_scan_t                scan_out
);

    logic [ID_W-1:0]          id_reg;
    logic [ID_W-1:0]          id_next;
    logic signed [PRIO_W-1:0] prio_reg;
    logic signed [PRIO_W-1:0] prio_next;
    spq_scan_t                scan_reg;
    spq_scan_t                scan_next;
    logic                     match;

    assign gt    = occ && (prio_reg > new_prio);
    assign match = occ && (id_reg == key);

    always_comb
    begin
        id_next   = id_reg;
        prio_next = prio_reg;
        if (ctrl.ins && !gt)
        begin
            if (prev_gt)
            begin
                id_next   = new_id;
                prio_next = new_prio;
            end
            else
            begin
                id_next   = prev_id;
                prio_next = prev_prio;
            end
        end
        else if (ctrl.rem)
        begin
            id_next   = next_id;
            prio_next = next_prio;
        end
    end

    always_comb
    begin
        scan_next = scan_in;
        if (!scan_in.found && match)
        begin
            scan_next.found = 1'b1;
            scan_next.prio  = prio_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
        if (ctrl.scan)
        begin
            scan_reg <= scan_next;
        end
    end

    assign id       = id_reg;
    assign prio     = prio_reg;
    assign scan_out = scan_reg;

endmodule

// File: hdl/sorted_priority_queue.sv
// ============================================================================
// sorted_priority_queue
// job queue kept sorted by descending priority in a chain of slot cells
// ============================================================================
// insert, remove and unused codes: result registered in the cycle after the beat
// search: result registered once the scan chain has been walked in ST_SCAN and read in ST_DONE
// one request in flight at a time; the next beat is taken once its result
// can be registered, not while the previous result waits on m_tready
// reset clears the job count, the control state and the output valid;
// slot contents are not cleared
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // job_id[31:0], job_priority[47:32]
    input  logic [REQ_W-1:0]       s_tuser,   // req_type[1:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // out_job_id[31:0], out_priority[47:32],
                                              // occupancy[52:48], zero[55:53]
    output logic [STAT_W-1:0]      m_tuser    // status[1:0]
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SCAN_W = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [SCAN_W-1:0]        scan_cnt_reg;
    logic [SCAN_W-1:0]        scan_cnt_next;
    logic [ID_W-1:0]          key_reg;
    logic [ID_W-1:0]          key_next;

    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic [STAT_W-1:0]        stat_reg;
    logic [STAT_W-1:0]        stat_next;
    logic [ID_W-1:0]          oid_reg;
    logic [ID_W-1:0]          oid_next;
    logic signed [PRIO_W-1:0] oprio_reg;
    logic signed [PRIO_W-1:0] oprio_next;
    logic [OCC_W-1:0]         occ_reg;
    logic [OCC_W-1:0]         occ_next;

    logic                     in_acc;
    logic [REQ_W-1:0]         req;
    logic [ID_W-1:0]          new_id;
    logic signed [PRIO_W-1:0] new_prio;
    logic                     full;
    logic                     empty;
    spq_ctrl_t                ctrl;

    logic                     cell_gt   [DEPTH];
    logic [ID_W-1:0]          cell_id   [DEPTH];
    logic signed [PRIO_W-1:0] cell_prio [DEPTH];
    spq_scan_t                cell_scan [DEPTH];
    logic                     cell_occ  [DEPTH];

    assign req      = s_tuser;
    assign new_id   = s_tdata[ID_W-1:0];
    assign new_prio = s_tdata[ID_W +: PRIO_W];
    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign in_acc   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    assign ctrl.ins  = in_acc && (req == REQ_INSERT) && !full;
    assign ctrl.rem  = in_acc && (req == REQ_REMOVE) && !empty;
    assign ctrl.scan = (state_reg == ST_SCAN);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                     prev_gt;
            logic [ID_W-1:0]          prev_id;
            logic signed [PRIO_W-1:0] prev_prio;
            logic [ID_W-1:0]          next_id;
            logic signed [PRIO_W-1:0] next_prio;
            spq_scan_t                scan_in;

            assign cell_occ[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign prev_gt   = 1'b1;
                assign prev_id   = new_id;
                assign prev_prio = new_prio;
                assign scan_in   = '0;
            end
            else
            begin : g_body
                assign prev_gt   = cell_gt[gi-1];
                assign prev_id   = cell_id[gi-1];
                assign prev_prio = cell_prio[gi-1];
                assign scan_in   = cell_scan[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign next_id   = cell_id[gi];
                assign next_prio = cell_prio[gi];
            end
            else
            begin : g_inner
                assign next_id   = cell_id[gi+1];
                assign next_prio = cell_prio[gi+1];
            end

            spq_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occ       (cell_occ[gi]),
                .prev_gt   (prev_gt),
                .new_id    (new_id),
                .new_prio  (new_prio),
                .key       (key_reg),
                .prev_id   (prev_id),
                .prev_prio (prev_prio),
                .next_id   (next_id),
                .next_prio (next_prio),
                .scan_in   (scan_in),
                .gt        (cell_gt[gi]),
                .id        (cell_id[gi]),
                .prio      (cell_prio[gi]),
                .scan_out  (cell_scan[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_cnt_next = scan_cnt_reg;
        key_next      = key_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        stat_next     = stat_reg;
        oid_next      = oid_reg;
        oprio_next    = oprio_reg;
        occ_next      = occ_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    stat_next  = STAT_OK;
                    oid_next   = '0;
                    oprio_next = '0;
                    if (req == REQ_INSERT)
                    begin
                        if (full)
                        begin
                            stat_next = STAT_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        m_valid_next = 1'b1;
                    end
                    else if (req == REQ_REMOVE)
                    begin
                        if (empty)
                        begin
                            stat_next = STAT_EMPTY;
                        end
                        else
                        begin
                            oid_next   = cell_id[0];
                            oprio_next = cell_prio[0];
                            count_next = count_reg - 1'b1;
                        end
                        m_valid_next = 1'b1;
                    end
                    else if (req == REQ_SEARCH)
                    begin
                        key_next      = new_id;
                        scan_cnt_next = '0;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        m_valid_next = 1'b1;
                    end
                    occ_next = OCC_W'(count_next);
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == SCAN_W'(DEPTH - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                m_valid_next = 1'b1;
                occ_next     = OCC_W'(count_reg);
                if (cell_scan[DEPTH-1].found)
                begin
                    stat_next  = STAT_OK;
                    oid_next   = key_reg;
                    oprio_next = cell_scan[DEPTH-1].prio;
                end
                else
                begin
                    stat_next  = STAT_NOT_FOUND;
                    oid_next   = '0;
                    oprio_next = '0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_cnt_reg <= scan_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        stat_reg  <= stat_next;
        oid_reg   <= oid_next;
        oprio_reg <= oprio_next;
        occ_reg   <= occ_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = stat_reg;
    assign m_tdata  = {(OUT_TDATA_W - ID_W - PRIO_W - OCC_W)'(0), occ_reg, oprio_reg, oid_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("job count above depth");

    a_no_result_while_scanning: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> !m_valid_reg)
        else $error("result valid during search scan");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && req == REQ_INSERT && !full |=>
            count_reg == $past(count_reg) + 1'b1 && m_valid_reg && stat_reg == STAT_OK)
        else $error("insert did not grow the queue");

    a_remove_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && req == REQ_REMOVE && empty |=>
            m_valid_reg && stat_reg == STAT_EMPTY && count_reg == '0)
        else $error("remove on empty queue misreported");

    a_search_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("search result not delivered");

endmodule

// File: verif/sorted_priority_queue_checker.sv
// ============================================================================
// sorted_priority_queue_checker
// watches both streams of the sorted priority queue, predicts each reply from
// its own copy of the job slots and compares every reply beat field by field
// ============================================================================
module sorted_priority_queue_checker
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // job_id[31:0], job_priority[47:32]
    input  logic [REQ_W-1:0]       s_tuser,   // req_type[1:0]
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // out_job_id[31:0], out_priority[47:32],
                                              // occupancy[52:48], zero[55:53]
    input  logic [STAT_W-1:0]      m_tuser,   // status[1:0]
    output int                     fail_count,
    output int                     replies_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAD_W = OUT_TDATA_W - ID_W - PRIO_W - OCC_W;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ID_W-1:0]    job_id;
        logic [PRIO_W-1:0]  prio;
        logic [OCC_W-1:0]   occupancy;
        logic [PAD_W-1:0]   pad;
    } reply_t;

    logic [ID_W-1:0]          held_ids   [DEPTH];
    logic signed [PRIO_W-1:0] held_prios [DEPTH];
    int                       held_count;
    reply_t                   replies_due [$];
    int                       errs;

    function automatic reply_t serve_request(input logic [REQ_W-1:0] kind,
                                             input logic [ID_W-1:0] id,
                                             input logic signed [PRIO_W-1:0] prio);
        reply_t r;
        int     pos;
        int     i;
        bit     found;
        r = '0;
        r.status = STAT_OK;
        case (kind)
            REQ_INSERT:
            begin
                if (held_count >= DEPTH)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < held_count && held_prios[pos] > prio)
                        pos++;
                    for (i = held_count; i > pos; i--)
                    begin
                        held_ids[i]   = held_ids[i-1];
                        held_prios[i] = held_prios[i-1];
                    end
                    held_ids[pos]   = id;
                    held_prios[pos] = prio;
                    held_count++;
                end
            end
            REQ_REMOVE:
            begin
                if (held_count == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    r.job_id = held_ids[0];
                    r.prio   = held_prios[0];
                    for (i = 1; i < held_count; i++)
                    begin
                        held_ids[i-1]   = held_ids[i];
                        held_prios[i-1] = held_prios[i];
                    end
                    held_count--;
                end
            end
            REQ_SEARCH:
            begin
                found = 1'b0;
                r.status = STAT_NOT_FOUND;
                for (i = 0; i < held_count && !found; i++)
                begin
                    if (held_ids[i] == id)
                    begin
                        found    = 1'b1;
                        r.status = STAT_OK;
                        r.job_id = held_ids[i];
                        r.prio   = held_prios[i];
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = held_count[OCC_W-1:0];
        return r;
    endfunction

    function automatic int field_differs(input string name, input logic [ID_W-1:0] want,
                                         input logic [ID_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        reply_t got;
        if (!rst_n)
        begin
            held_count = 0;
            errs = 0;
            replies_due.delete();
            fail_count   <= 0;
            replies_owed <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status    = m_tuser;
                got.job_id    = m_tdata[ID_W-1:0];
                got.prio      = m_tdata[ID_W+PRIO_W-1:ID_W];
                got.occupancy = m_tdata[ID_W+PRIO_W+OCC_W-1:ID_W+PRIO_W];
                got.pad       = m_tdata[OUT_TDATA_W-1:ID_W+PRIO_W+OCC_W];
                if (replies_due.size() == 0)
                begin
                    $display("%0t: reply beat with none expected, actual %0h", $time, got);
                    errs++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    errs += field_differs("status", ID_W'(want.status), ID_W'(got.status));
                    errs += field_differs("out_job_id", want.job_id, got.job_id);
                    errs += field_differs("out_priority", ID_W'(want.prio), ID_W'(got.prio));
                    errs += field_differs("occupancy", ID_W'(want.occupancy),
                                          ID_W'(got.occupancy));
                    errs += field_differs("padding", ID_W'(want.pad), ID_W'(got.pad));
                end
            end
            if (s_tvalid && s_tready)
                replies_due.push_back(serve_request(s_tuser, s_tdata[ID_W-1:0],
                                                    s_tdata[ID_W+PRIO_W-1:ID_W]));
            fail_count   <= errs;
            replies_owed <= replies_due.size();
        end
    end

endmodule

// File: verif/sorted_priority_queue_tb.sv
// ============================================================================
// sorted_priority_queue_tb
// drives job requests into the sorted priority queue in bursts, stalls the
// reply stream, and leaves prediction and comparison to the checker
// ============================================================================
module sorted_priority_queue_tb;
    import spq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 1000;
    localparam int TAIL_CYCLES  = 2 * DEPTH_DEF + 8;
    localparam int STALL_LIMIT  = 2000;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [REQ_W-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]      m_tuser;
    int                     fail_count;
    int                     replies_owed;

    logic [ID_W-1:0]        recent_ids [$];
    int                     idle_cycles = 0;
    int                     ready_mode = 0;
    int                     ready_left = 0;

    sorted_priority_queue i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sorted_priority_queue_checker i_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .replies_owed (replies_owed)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // reply side stall pattern: always ready, coin flip, or mostly stalled
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode <= $urandom_range(0, 2);
            ready_left <= $urandom_range(10, 200);
        end
        else
        begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] id,
                            input logic signed [PRIO_W-1:0] prio);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {prio, id};
        if (kind == REQ_INSERT)
        begin
            recent_ids.push_back(id);
            if (recent_ids.size() > 24)
                void'(recent_ids.pop_front());
        end
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    function automatic logic [REQ_W-1:0] pick_kind(input bit filling);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return REQ_UNUSED;
        if (roll < 20)
            return REQ_SEARCH;
        if (roll < 80)
            return filling ? REQ_INSERT : REQ_REMOVE;
        return filling ? REQ_REMOVE : REQ_INSERT;
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        int roll;
        roll = $urandom_range(0, 11);
        if (roll < 4 && recent_ids.size() > 0)
            return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        if (roll < 6)
            return $urandom_range(0, 7);
        if (roll == 6)
            return $urandom_range(0, 1) ? '1 : '0;
        return $urandom;
    endfunction

    function automatic logic signed [PRIO_W-1:0] pick_prio();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll < 2)
            return PRIO_W'($signed($urandom_range(0, 6)) - 3);
        if (roll == 2)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'sh8000;
                1:       return 16'sh7fff;
                2:       return -16'sd1;
                default: return 16'sd0;
            endcase
        end
        return PRIO_W'($urandom);
    endfunction

    initial
    begin
        int sent;
        int burst;
        int k;
        int phase_left;
        bit filling;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue cases and the unused code
        send_req(REQ_REMOVE, 32'h0, 16'sd0);
        send_req(REQ_SEARCH, 32'h0, 16'sd0);
        send_req(REQ_UNUSED, 32'hdead_beef, 16'sh1234);
        // extreme ids and priorities, ties at zero and at the top
        send_req(REQ_INSERT, 32'h0, 16'sh8000);
        send_req(REQ_INSERT, 32'hffff_ffff, 16'sh7fff);
        send_req(REQ_INSERT, 32'h1, 16'sd0);
        send_req(REQ_INSERT, 32'h2, 16'sd0);
        send_req(REQ_INSERT, 32'h3, -16'sd1);
        send_req(REQ_INSERT, 32'h4, 16'sh7fff);
        send_req(REQ_SEARCH, 32'h0, 16'sd0);
        send_req(REQ_SEARCH, 32'h1234_5678, 16'sd0);
        // duplicate id: search finds the one nearer the front
        send_req(REQ_INSERT, 32'h1, 16'sd5);
        send_req(REQ_SEARCH, 32'h1, 16'sd0);
        send_req(REQ_UNUSED, 32'hffff_ffff, 16'sh8000);
        repeat (8) send_req(REQ_REMOVE, 32'h0, 16'sd0);
        send_req(REQ_SEARCH, 32'hffff_ffff, 16'sd0);

        sent = 0;
        phase_left = 0;
        filling = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            for (k = 0; k < burst && sent < RANDOM_ITEMS; k++)
            begin
                if (phase_left == 0)
                begin
                    filling = ~filling;
                    phase_left = $urandom_range(30, 80);
                end
                phase_left--;
                send_req(pick_kind(filling), pick_id(), pick_prio());
                sent++;
            end
            idle_gap(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 5));
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (replies_owed == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
